[src/sha512_stream_hasher_unit_defines.svh]
// Assertion macros used by the SHA-512 stream hasher datapath.
// No dependencies.
`ifndef SHA512_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA512_STREAM_HASHER_UNIT_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define SHU_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define SHU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/shu_pkg.sv]
// Package for the SHA-512 stream hasher: types, constants, a rotate function.
// No dependencies.
`timescale 1ns / 1ps
package shu_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_PAD_80,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_EMIT
  } shu_state_t;

  typedef struct packed {
    logic wr_byte;
    logic wr_pad80;
    logic wr_zero;
    logic wr_len;
    logic clr_msg;
    logic load_vars;
    logic do_round;
    logic add_hash;
    logic reset_hash;
    logic clr_round;
    logic out_load;
  } shu_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic       round_last;
    logic       out_last;
  } shu_sts_t;

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [6:0] LEN_START = 7'd112;
  localparam logic [6:0] LEN_LAST  = 7'd127;
  localparam logic [6:0] FILL_LAST = 7'd127;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

[src/shu_ctrl.sv]
// Controller for the SHA-512 stream hasher: sequences absorb, pad, rounds, emit.
// Depends on shu_pkg.
`timescale 1ns / 1ps
module shu_ctrl import shu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       byte_valid,
  input  logic       finish,
  output logic       in_ready,
  output shu_cmd_t   cmd,
  input  shu_sts_t   sts
);

  shu_state_t state, state_next;
  logic fin_pend, fin_pend_next;   // finish still to run after a block
  logic final_blk, final_blk_next; // compressing the length block
  logic full_pad, full_pad_next;   // padding the extra block before the length one

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fin_pend  <= 1'b0;
      final_blk <= 1'b0;
      full_pad  <= 1'b0;
    end else begin
      state     <= state_next;
      fin_pend  <= fin_pend_next;
      final_blk <= final_blk_next;
      full_pad  <= full_pad_next;
    end
  end

  always_comb begin
    state_next     = state;
    fin_pend_next  = fin_pend;
    final_blk_next = final_blk;
    full_pad_next  = full_pad;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_valid && sts.fill == FILL_LAST) begin
            state_next    = ST_INIT;
            fin_pend_next = finish;
          end else if (finish) begin
            state_next = ST_PAD_80;
          end
        end
      end
      ST_INIT: state_next = ST_ROUND;
      ST_ROUND: if (sts.round_last) state_next = ST_ADD;
      ST_ADD: begin
        if (final_blk) begin
          state_next     = ST_EMIT;
          final_blk_next = 1'b0;
        end else if (full_pad) begin
          state_next    = ST_PAD_ZERO;
          full_pad_next = 1'b0;
        end else if (fin_pend) begin
          state_next    = ST_PAD_80;
          fin_pend_next = 1'b0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD_80: begin
        if (sts.fill > LEN_START - 7'd1 || sts.fill == FILL_LAST) begin
          // 0x80 lands at 112 or later: finish this block first, zero-filling any bytes left
          state_next = (sts.fill == FILL_LAST) ? ST_INIT : ST_PAD_ZERO;
          full_pad_next = (sts.fill != FILL_LAST);
          if (sts.fill == FILL_LAST) full_pad_next = 1'b1;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (full_pad) begin
          if (sts.fill == FILL_LAST) state_next = ST_INIT;
        end else if (sts.fill == LEN_START - 7'd1 || sts.fill >= LEN_START) begin
          state_next = ST_PAD_LEN;
        end
      end
      ST_PAD_LEN: begin
        if (sts.fill == LEN_LAST) begin
          state_next     = ST_INIT;
          final_blk_next = 1'b1;
        end
      end
      ST_EMIT: if (sts.out_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.wr_byte = in_valid && byte_valid;
      end
      ST_INIT: cmd.load_vars = 1'b1;
      ST_ROUND: cmd.do_round = 1'b1;
      ST_ADD: begin
        cmd.add_hash  = 1'b1;
        cmd.clr_round = 1'b1;
        cmd.out_load  = final_blk;
      end
      ST_PAD_80: cmd.wr_pad80 = 1'b1;
      ST_PAD_ZERO: cmd.wr_zero = !(!full_pad && sts.fill >= LEN_START);
      ST_PAD_LEN: cmd.wr_len = 1'b1;
      ST_EMIT: begin
        if (sts.out_last) begin
          cmd.reset_hash = 1'b1;
          cmd.clr_msg    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/shu_datapath.sv]
// Datapath for the SHA-512 stream hasher: block buffer, schedule, rounds, digest out.
// Depends on shu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sha512_stream_hasher_unit_defines.svh"
module shu_datapath import shu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  shu_cmd_t    cmd,
  output shu_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic [63:0] buffer [16];
  logic [6:0]  fill;
  logic [63:0] message_bits;
  logic [63:0] hash [8];
  logic [63:0] vars [8];
  logic [63:0] sched [16];
  logic [6:0]  round;
  logic [63:0] out_words [8];
  logic [2:0]  out_idx;
  logic        out_busy;

  logic [63:0] w, t1, t2, s0, s1, w2, w15, blk_word, a, b, c, e, f, g;
  logic [3:0]  rnd4;

  assign rnd4 = round[3:0];
  assign a = vars[0];
  assign b = vars[1];
  assign c = vars[2];
  assign e = vars[4];
  assign f = vars[5];
  assign g = vars[6];

  assign blk_word = buffer[rnd4];

  assign w2  = sched[rnd4 - 4'd2];
  assign w15 = sched[rnd4 - 4'd15];
  assign s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
  assign s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
  assign w   = (round < 7'd16) ? blk_word : (s1 + sched[rnd4 - 4'd7] + s0 + sched[rnd4]);
  assign t1  = vars[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + (g ^ (e & (f ^ g)))
             + ROUND_K[round] + w;
  assign t2  = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) | (c & (a | b)));

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) buffer[fill[6:3]][8*(7 - fill[2:0]) +: 8] <= data_byte;
    else if (cmd.wr_pad80) buffer[fill[6:3]][8*(7 - fill[2:0]) +: 8] <= PAD_BYTE;
    else if (cmd.wr_zero) buffer[fill[6:3]][8*(7 - fill[2:0]) +: 8] <= 8'h00;
    else if (cmd.wr_len)
      buffer[fill[6:3]][8*(7 - fill[2:0]) +: 8] <=
        fill[3] ? message_bits[8*(7 - fill[2:0]) +: 8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      message_bits <= '0;
      round        <= '0;
      out_busy     <= 1'b0;
      out_idx      <= '0;
      for (int j = 0; j < 8; j++) hash[j] <= INIT_HASH[j];
    end else begin
      if (cmd.wr_byte || cmd.wr_pad80 || cmd.wr_zero || cmd.wr_len) fill <= fill + 7'd1;
      if (cmd.wr_byte) message_bits <= message_bits + 64'd8;
      if (cmd.clr_msg) begin
        message_bits <= '0;
        fill         <= '0;
      end
      if (cmd.do_round) round <= round + 7'd1;
      if (cmd.clr_round) round <= '0;
      if (cmd.add_hash) begin
        for (int j = 0; j < 8; j++) hash[j] <= hash[j] + vars[j];
      end
      if (cmd.reset_hash) begin
        for (int j = 0; j < 8; j++) hash[j] <= INIT_HASH[j];
      end
      if (cmd.out_load) begin
        out_busy <= 1'b1;
        out_idx  <= '0;
      end else if (out_busy && out_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) out_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int j = 0; j < 8; j++) vars[j] <= hash[j];
    end else if (cmd.do_round) begin
      sched[rnd4] <= w;
      for (int j = 1; j < 8; j++) vars[j] <= vars[j - 1];
      vars[4] <= vars[3] + t1;
      vars[0] <= t1 + t2;
    end
    if (cmd.add_hash) begin
      for (int j = 0; j < 8; j++) out_words[j] <= hash[j] + vars[j];
    end
  end

  assign out_valid   = out_busy;
  assign digest_word = out_words[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  assign sts.fill       = fill;
  assign sts.round_last = (round == LAST_ROUND);
  assign sts.out_last   = out_busy && out_ready && out_idx == 3'd7;

  `SHU_ASSERT_IMPL(a_no_round_while_out, clk, rst, cmd.do_round, !out_busy,
    "round while digest pending")
  `SHU_ASSERT_NEXT(a_last_clears, clk, rst, out_busy && out_ready && last_word, !out_busy,
    "output did not drain after last word")
  `SHU_ASSERT_IMPL(a_idx_last, clk, rst, out_valid && last_word, word_index == 3'd7,
    "last word index mismatch")

endmodule

[src/sha512_stream_hasher_unit.sv]
// Top level of the SHA-512 stream hasher: controller plus datapath.
// Depends on shu_pkg, shu_ctrl and shu_datapath.
//
// Input channel: in_valid/in_ready, fields data_byte, byte_valid, finish.
// Bytes stream at one beat per cycle while in_ready is high.
// The byte that fills the 128-byte buffer starts a compression: a setup
// step, 80 rounds and an add step, during which in_ready is low; the round
// unit evaluates one round per cycle.
// A finish beat pads (one buffer byte per cycle up to offset 127), then
// compresses once or twice, then presents eight digest words on
// out_valid/out_ready, word 0 first, last_word on word 7, one per cycle
// while out_ready is high. The time from the finish beat to the first
// digest word is set by the fill at finish and by whether an extra block
// is needed. A stalled receiver holds the current word; no input is taken
// until the last word is taken. Reset restores the initial hash, clears the
// length and fill, and drops any pending digest.
`timescale 1ns / 1ps
module sha512_stream_hasher_unit import shu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        finish,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  shu_cmd_t cmd;
  shu_sts_t sts;

  shu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .byte_valid(byte_valid),
    .finish(finish), .in_ready(in_ready), .cmd(cmd), .sts(sts));

  shu_datapath u_dp (
    .clk(clk), .rst(rst), .data_byte(data_byte), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word));

endmodule

[sim/sha512_stream_hasher_unit_test.sv]
// Testbench for sha512_stream_hasher_unit: byte beats in, digest words out, checked
// against an in-bench SHA-512 predictor. Depends on shu_pkg and the RTL top level.
`timescale 1ns / 1ps
module sha512_stream_hasher_unit_test import shu_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int N_ROWS = 22;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       bv;
    logic       fin;
  } byte_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        finish = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha512_stream_hasher_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0]  hash_st [8];
  logic [7:0]   blk [128];
  int           fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];
  int           errors = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;
  bit           timed_out = 1'b0;
  byte_beat_t   rows [N_ROWS];

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_blk();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      for (int j = 0; j < 8; j++) w[t] = {w[t][55:0], blk[t * 8 + j]};
    for (int t = 16; t < 80; t++) begin
      s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
      s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int j = 0; j < 8; j++) v[j] = hash_st[j];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_K[t] + w[t];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_st[j] += v[j];
  endtask

  task automatic predict_beat(byte_beat_t b);
    digest_beat_t d;
    if (b.bv) begin
      blk[fill] = b.data;
      fill++;
      msg_bits += 8;
      if (fill == 128) begin
        compress_blk();
        fill = 0;
      end
    end
    if (b.fin) begin
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > 112) begin
        while (fill < 128) blk[fill++] = 8'h00;
        compress_blk();
        fill = 0;
      end
      while (fill < 120) blk[fill++] = 8'h00;
      for (int j = 0; j < 8; j++) blk[120 + j] = msg_bits[63 - 8 * j -: 8];
      compress_blk();
      for (int j = 0; j < 8; j++) begin
        d.word = hash_st[j];
        d.idx = j[2:0];
        d.last = (j == 7);
        digest_q.push_back(d);
        hash_st[j] = INIT_HASH[j];
      end
      fill = 0;
      msg_bits = '0;
    end
  endtask

  function automatic bit stall_now();
    return !quiet && ($urandom_range(99) < 14);
  endfunction

  task automatic send_beat(byte_beat_t b);
    while (stall_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b.data;
    byte_valid <= b.bv;
    finish <= b.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b);
    @(negedge clk);
  endtask

  task automatic send_message(int len);
    byte_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.data = $urandom_range(255);
      b.bv = 1'b1;
      b.fin = 1'b0;
      if ($urandom_range(9) == 0) begin
        b.bv = 1'b0;
        send_beat(b);
        b.bv = 1'b1;
      end
      if (i == len - 1 && $urandom_range(1)) b.fin = 1'b1;
      send_beat(b);
    end
    if (len == 0 || !b.fin) begin
      b.data = $urandom_range(255);
      b.bv = 1'b0;
      b.fin = 1'b1;
      send_beat(b);
    end
  endtask

  always @(negedge clk) out_ready <= rst ? 1'b0 : !stall_now();

  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word exp none act %h idx %0d last %b",
                 $time, digest_word, word_index, last_word);
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word) begin
          errors++;
          $display("%0t: digest_word exp %h act %h", $time, e.word, digest_word);
        end
        if (word_index !== e.idx) begin
          errors++;
          $display("%0t: word_index exp %0d act %0d", $time, e.idx, word_index);
        end
        if (last_word !== e.last) begin
          errors++;
          $display("%0t: last_word exp %b act %b", $time, e.last, last_word);
        end
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("sha512_stream_hasher_unit_test: errors");
      $finish;
    end
  end

  initial begin
    digest_beat_t e;
    for (int j = 0; j < 8; j++) hash_st[j] = INIT_HASH[j];
    fill = 0;
    msg_bits = '0;
    // empty message, idle beats, extremes of data_byte, finish carrying a byte
    rows[0] = '{8'hff, 1'b0, 1'b1};
    rows[1] = '{8'h00, 1'b0, 1'b0};
    rows[2] = '{8'h00, 1'b1, 1'b0};
    rows[3] = '{8'hff, 1'b1, 1'b1};
    rows[4] = '{8'h61, 1'b1, 1'b0};
    rows[5] = '{8'h62, 1'b1, 1'b0};
    rows[6] = '{8'h63, 1'b0, 1'b0};
    rows[7] = '{8'h63, 1'b1, 1'b1};
    rows[8] = '{8'h00, 1'b0, 1'b1};
    for (int i = 9; i < N_ROWS; i++) rows[i] = '{8'h55 ^ i[7:0], 1'b1, i == N_ROWS - 1};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_ROWS; i++) begin
      send_beat(rows[i]);
      if (i == 0) begin
        e = digest_q[0];
        if (e.word !== 64'hcf83e1357eefb8bd) begin
          errors++;
          $display("%0t: empty digest exp %h act %h", $time, 64'hcf83e1357eefb8bd, e.word);
        end
      end
    end
    // length past the 112 boundary, so padding needs an extra block
    send_message(115);
    quiet = 1'b1;
    send_message(30);
    quiet = 1'b0;
    for (int m = 0; m < 3; m++) send_message($urandom_range(20));
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("sha512_stream_hasher_unit_test: clean");
    else $display("sha512_stream_hasher_unit_test: errors");
    $finish;
  end
endmodule

[sha512_stream_hasher_unit.f]
+incdir+src
src/shu_pkg.sv
src/shu_ctrl.sv
src/shu_datapath.sv
src/sha512_stream_hasher_unit.sv
sim/sha512_stream_hasher_unit_test.sv
